// ===== design/dwa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dwa_pkg;
	localparam int MEM_WORDS = 1000;
	localparam int REG_COUNT = 4;
	localparam int AW = $clog2(MEM_WORDS);
	localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	localparam logic [2:0] ST_RUN     = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_BADREG  = 3'd2;
	localparam logic [2:0] ST_BADFLAG = 3'd3;
	localparam logic [2:0] ST_DIVZERO = 3'd4;
	localparam logic [2:0] ST_OVERRUN = 3'd5;

	localparam logic [3:0] OP_HALT  = 4'd0;
	localparam logic [3:0] OP_READ  = 4'd1;
	localparam logic [3:0] OP_PRINT = 4'd2;
	localparam logic [3:0] OP_ADD   = 4'd3;
	localparam logic [3:0] OP_SUB   = 4'd4;
	localparam logic [3:0] OP_LOAD  = 4'd5;
	localparam logic [3:0] OP_STORE = 4'd6;
	localparam logic [3:0] OP_MUL   = 4'd7;
	localparam logic [3:0] OP_DIV   = 4'd8;
	localparam logic [3:0] OP_BR    = 4'd9;
	localparam logic [3:0] OP_CMP   = 4'd10;

	// datapath commands
	typedef enum logic [3:0] {
		C_NONE, C_LOADW, C_CLR, C_FETCH, C_DEC, C_OPRD, C_EXEC, C_ITER, C_FIN
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} dp_cmd_t;

	typedef struct packed {
		logic running;
		logic clr_done;
		logic iter_done;
		logic long_op;
	} dp_stat_t;
endpackage
`default_nettype wire

// ===== design/decimal_word_accumulator_cpu_step_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// decimal word accumulator machine, one item per transfer
// slave channel: s_tdata carries address and value, s_tuser carries action
// (0 writes a memory word and restarts at pc 0, 1 runs one instruction)
// master channel: m_tdata carries pc, print_value and status; m_tuser print_valid
// one result transfer follows each input transfer
// a load or a step of a stopped machine is finished in the idle state; a normal
// instruction passes the fetch, operand-read, decode and execute states; multiply
// and divide then run on the shared shift-add / restoring-divide unit (32 steps,
// then an exit state and a write-back)
// a new input is taken only when the previous one is finished and its
// result has been taken
// after reset a clearing pass zeroes all 1000 memory words, one word
// per cycle, with s_tready low; registers and flags clear at once
// the result is held in the output register until taken; while it waits
// s_tready stays low, so a stalled receiver stalls the input side
module decimal_word_accumulator_cpu_step_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // address[9:0], value[41:10]
	input  wire logic        s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // pc[9:0], print_value[41:10], status[44:42]
	output logic             m_tuser   // print_valid
);
	dwa_pkg::dp_cmd_t  cmd;
	dwa_pkg::dp_stat_t stat;
	logic [9:0]  pc;
	logic [31:0] pval;
	logic [2:0]  st;
	logic        unused_hi;
	assign unused_hi = ^s_tdata[47:42];

	dwa_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .action(s_tuser),
		.m_tvalid, .m_tready, .stat, .cmd
	);

	dwa_datapath u_dp (
		.clk, .arst_n, .cmd, .address(s_tdata[9:0]),
		.value(s_tdata[41:10]), .stat, .pc, .print_valid(m_tuser),
		.print_value(pval), .status(st)
	);

	assign m_tdata = {3'd0, st, pval, pc};
endmodule
`default_nettype wire

// ===== design/dwa_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dwa_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dwa_pkg::dp_cmd_t cmd,
	input  wire logic [9:0]      address,
	input  wire logic [31:0]     value,
	output dwa_pkg::dp_stat_t    stat,
	output logic [9:0]           pc,
	output logic                 print_valid,
	output logic [31:0]          print_value,
	output logic [2:0]           status
);
	logic [31:0] mem [dwa_pkg::MEM_WORDS];
	logic [31:0] regs_q [dwa_pkg::REG_COUNT];
	logic [4:0]  flags_q;
	logic [dwa_pkg::AW-1:0] pc_q, clr_q;
	logic [2:0]  st_q;
	logic [31:0] rd_q, w_q, val_q;
	logic [3:0]  op_q;
	logic [3:0]  r_q;
	logic [9:0]  a_q;
	logic        bad_q, pv_q;
	logic [31:0] pval_q;
	// iterative unit
	logic [31:0] acc_q, opa_q, opb_q;
	logic [5:0]  cnt_q;
	logic        neg_q;

	// memory port
	logic        we;
	logic [dwa_pkg::AW-1:0] waddr, raddr;
	logic [31:0] wdata;

	// decode: digits by reciprocal multiply with correction
	logic [16:0] w17;
	logic [33:0] qp;
	logic [3:0]  q10k, opd;
	logic [13:0] rem10k;
	logic [27:0] qr;
	logic [3:0]  rdig;
	logic [9:0]  adig;
	always_comb begin
		w17 = w_q[16:0];
		qp = 34'(w17) * 34'd107375;
		q10k = qp[33:30];
		rem10k = 14'(w17 - 17'(q10k) * 17'd10000);
		opd = q10k;
		if (rem10k >= 14'd10000) begin
			opd = q10k + 4'd1;
			rem10k = rem10k - 14'd10000;
		end
		qr = 28'(rem10k) * 28'd16778;
		rdig = qr[27:24];
		adig = 10'(rem10k - 14'(rdig) * 14'd1000);
		if (adig >= 10'd1000) begin
			rdig = rdig + 4'd1;
			adig = adig - 10'd1000;
		end
	end

	logic [dwa_pkg::RW-1:0] ri;
	logic a_ok;
	logic [31:0] m;
	logic [31:0] x;
	logic lt, eq;
	logic [dwa_pkg::AW:0] pc_inc;
	logic badreg;
	assign ri = dwa_pkg::RW'(r_q - 4'd1);
	assign a_ok = 32'(a_q) < 32'(dwa_pkg::MEM_WORDS);
	assign m = a_ok ? rd_q : 32'd0;
	assign x = regs_q[ri];
	assign lt = $signed(x) < $signed(m);
	assign eq = x == m;
	assign pc_inc = {1'b0, pc_q} + 1'b1;
	// register digit out of range for an instruction that names a register
	assign badreg = ((op_q >= dwa_pkg::OP_ADD && op_q <= dwa_pkg::OP_DIV) ||
		op_q == dwa_pkg::OP_CMP) &&
		(r_q == 4'd0 || 32'(r_q) > 32'(dwa_pkg::REG_COUNT));

	always_comb begin
		we = 1'b0;
		waddr = clr_q;
		wdata = 32'd0;
		raddr = pc_q;
		unique case (cmd.cmd)
			dwa_pkg::C_CLR: we = 1'b1;
			dwa_pkg::C_LOADW: begin
				we = 32'(address) < 32'(dwa_pkg::MEM_WORDS);
				waddr = dwa_pkg::AW'(address);
				wdata = value;
			end
			dwa_pkg::C_DEC: raddr = dwa_pkg::AW'(adig);
			dwa_pkg::C_EXEC: begin
				waddr = dwa_pkg::AW'(a_q);
				we = a_ok && !bad_q && !badreg && (op_q == dwa_pkg::OP_READ ||
					op_q == dwa_pkg::OP_STORE);
				wdata = (op_q == dwa_pkg::OP_READ) ? val_q : x;
			end
			default: ;
		endcase
	end

	// memory
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign stat.running   = st_q == dwa_pkg::ST_RUN;
	assign stat.clr_done  = 32'(clr_q) == 32'(dwa_pkg::MEM_WORDS - 1);
	assign stat.iter_done = cnt_q == 6'd0;
	assign stat.long_op   = !bad_q && !badreg && (op_q == dwa_pkg::OP_MUL ||
		(op_q == dwa_pkg::OP_DIV && m != 32'd0));

	// state and execution
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dwa_pkg::REG_COUNT; i++) regs_q[i] <= '0;
			flags_q <= '0;
			pc_q <= '0;
			st_q <= dwa_pkg::ST_RUN;
			clr_q <= '0;
			pv_q <= 1'b0;
			pval_q <= '0;
		end else begin
			unique case (cmd.cmd)
				dwa_pkg::C_CLR: clr_q <= clr_q + 1'b1;
				dwa_pkg::C_LOADW: begin
					pc_q <= '0;
					st_q <= dwa_pkg::ST_RUN;
					pv_q <= 1'b0;
					pval_q <= '0;
				end
				dwa_pkg::C_FETCH: begin
					pv_q <= 1'b0;
					pval_q <= '0;
				end
				dwa_pkg::C_EXEC: begin
					priority if (bad_q) begin
						if (pc_inc >= (dwa_pkg::AW+1)'(dwa_pkg::MEM_WORDS))
							st_q <= dwa_pkg::ST_OVERRUN;
						else pc_q <= pc_inc[dwa_pkg::AW-1:0];
					end else if (badreg) begin
						st_q <= dwa_pkg::ST_BADREG;
					end else begin
						unique case (op_q)
							dwa_pkg::OP_HALT: st_q <= dwa_pkg::ST_HALT;
							dwa_pkg::OP_BR: begin
								if (r_q > 4'd5) st_q <= dwa_pkg::ST_BADFLAG;
								else if (r_q == 4'd5 || flags_q[r_q[2:0]]) begin
									if (a_ok) pc_q <= dwa_pkg::AW'(a_q);
									else st_q <= dwa_pkg::ST_OVERRUN;
								end else if (pc_inc >=
									(dwa_pkg::AW+1)'(dwa_pkg::MEM_WORDS))
									st_q <= dwa_pkg::ST_OVERRUN;
								else pc_q <= pc_inc[dwa_pkg::AW-1:0];
							end
							dwa_pkg::OP_DIV: begin
								if (m == 32'd0) st_q <= dwa_pkg::ST_DIVZERO;
							end
							dwa_pkg::OP_MUL: ;
							default: begin
								if (op_q == dwa_pkg::OP_PRINT) begin
									pv_q <= 1'b1;
									pval_q <= m;
								end
								if (op_q == dwa_pkg::OP_ADD) regs_q[ri] <= x + m;
								if (op_q == dwa_pkg::OP_SUB) regs_q[ri] <= x - m;
								if (op_q == dwa_pkg::OP_LOAD) regs_q[ri] <= m;
								if (op_q == dwa_pkg::OP_CMP)
									flags_q <= {!lt, !lt && !eq, eq, lt || eq, lt};
								if (pc_inc >= (dwa_pkg::AW+1)'(dwa_pkg::MEM_WORDS))
									st_q <= dwa_pkg::ST_OVERRUN;
								else pc_q <= pc_inc[dwa_pkg::AW-1:0];
							end
						endcase
					end
				end
				dwa_pkg::C_FIN: begin
					if (op_q == dwa_pkg::OP_MUL) regs_q[ri] <= acc_q;
					else regs_q[ri] <= neg_q ? 32'd0 - opa_q : opa_q;
					if (pc_inc >= (dwa_pkg::AW+1)'(dwa_pkg::MEM_WORDS))
						st_q <= dwa_pkg::ST_OVERRUN;
					else pc_q <= pc_inc[dwa_pkg::AW-1:0];
				end
				default: ;
			endcase
		end
	end

	// decode and iterative multiply / divide
	logic [32:0] trial;
	always_comb trial = {acc_q, opa_q[31]} - {1'b0, opb_q};
	always_ff @(posedge clk) begin
		unique case (cmd.cmd)
			dwa_pkg::C_FETCH: val_q <= value;
			dwa_pkg::C_OPRD: w_q <= rd_q;
			dwa_pkg::C_DEC: begin
				bad_q <= w_q[31] || w_q > 32'd109999;
				op_q <= opd;
				r_q <= rdig;
				a_q <= adig;
			end
			dwa_pkg::C_EXEC: begin
				cnt_q <= 6'd32;
				acc_q <= '0;
				if (op_q == dwa_pkg::OP_MUL) begin
					opa_q <= x;
					opb_q <= m;
				end else begin
					opa_q <= x[31] ? 32'd0 - x : x;
					opb_q <= m[31] ? 32'd0 - m : m;
					neg_q <= x[31] ^ m[31];
				end
			end
			dwa_pkg::C_ITER: begin
				cnt_q <= cnt_q - 6'd1;
				if (op_q == dwa_pkg::OP_MUL) begin
					acc_q <= acc_q + (opb_q[0] ? opa_q : 32'd0);
					opa_q <= opa_q << 1;
					opb_q <= opb_q >> 1;
				end else if (!trial[32]) begin
					acc_q <= trial[31:0];
					opa_q <= {opa_q[30:0], 1'b1};
				end else begin
					acc_q <= {acc_q[30:0], opa_q[31]};
					opa_q <= {opa_q[30:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign pc = 10'(pc_q);
	assign print_valid = pv_q;
	assign print_value = pval_q;
	assign status = st_q;
endmodule
`default_nettype wire

// ===== design/dwa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dwa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic             action,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire dwa_pkg::dp_stat_t stat,
	output dwa_pkg::dp_cmd_t      cmd
);
	localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_FETCH = 3'd2,
		S_OPRD = 3'd3, S_DEC = 3'd4, S_EXEC = 3'd5, S_ITER = 3'd6, S_FIN = 3'd7;
	logic [2:0] state_q, state_d;
	logic ovalid_q;
	logic take, done;

	assign s_tready = state_q == S_IDLE && !ovalid_q;
	assign take = s_tvalid && s_tready;
	assign m_tvalid = ovalid_q;

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.cmd = dwa_pkg::C_NONE;
		done = 1'b0;
		unique case (state_q)
			S_CLR: begin
				cmd.cmd = dwa_pkg::C_CLR;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: if (take) begin
				if (!action) begin
					cmd.cmd = dwa_pkg::C_LOADW;
					done = 1'b1;
				end else if (!stat.running) begin
					// stopped machine: only the print flag and print value clear
					cmd.cmd = dwa_pkg::C_FETCH;
					done = 1'b1;
				end else begin
					cmd.cmd = dwa_pkg::C_FETCH;
					state_d = S_FETCH;
				end
			end
			S_FETCH: state_d = S_OPRD;
			S_OPRD: begin
				cmd.cmd = dwa_pkg::C_OPRD;
				state_d = S_DEC;
			end
			S_DEC: begin
				cmd.cmd = dwa_pkg::C_DEC;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.cmd = dwa_pkg::C_EXEC;
				if (stat.long_op) state_d = S_ITER;
				else begin
					state_d = S_IDLE;
					done = 1'b1;
				end
			end
			S_ITER: begin
				cmd.cmd = dwa_pkg::C_ITER;
				if (stat.iter_done) begin
					cmd.cmd = dwa_pkg::C_NONE;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.cmd = dwa_pkg::C_FIN;
				state_d = S_IDLE;
				done = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== design/dwa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dwa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tuser
);
	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	// no input taken while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted with result pending");
	// status in range
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[44:42] <= 3'd5)
		else $error("bad status");
	// print only while running or after an overrun
	a_pr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[44:42] == 3'd0 || m_tdata[44:42] == 3'd5)
		else $error("print with stopped status");
	logic unused;
	assign unused = s_tvalid;
endmodule
bind decimal_word_accumulator_cpu_step_top dwa_checker u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
`default_nettype wire
